[rtl/slnc_pkg.sv]
// Shared constants, types and the coefficient table of the scratch low-pass noise colorer.
package slnc_pkg;

   typedef longint unsigned u64_type;

   localparam int SAMPLE_W  = 24;
   localparam int EXP_DEPTH = 64;
   localparam int IDX_W     = $clog2(EXP_DEPTH);
   localparam int COEF_W    = 17;
   localparam int SR_W      = 18;
   localparam int FC_W      = 14;
   localparam int Q_W       = 16;

   localparam u64_type TWO_PI_Q30 = 64'd6746518852;
   localparam u64_type ONE_Q30    = 64'd1073741824;

   localparam logic [SR_W-1:0] SR_RESET   = 18'd48000;
   localparam logic [1:0]      NCH_RESET  = 2'd2;
   localparam logic [31:0]     SEED_RESET = 32'h9e37_79b9;
   localparam logic [31:0]     LCG_MUL    = 32'd1664525;
   localparam logic [31:0]     LCG_ADD    = 32'd1013904223;

   localparam logic [14:0] STRENGTH_HIGH   = 15'd18842;
   localparam logic [14:0] STRENGTH_NORMAL = 15'd13435;
   localparam logic [13:0] BASE_HIGH       = 14'd7200;
   localparam logic [13:0] BASE_NORMAL     = 14'd11200;
   localparam logic [15:0] K_SPEED         = 16'd34079;
   localparam logic [15:0] K_REVERSE       = 16'd12452;
   localparam logic [21:0] K_AMP_SLOPE     = 22'd2791729;
   localparam logic [22:0] K_AMP_BASE      = 23'd3006477;
   localparam logic [12:0] K_SMOOTH        = 13'd5898;
   localparam logic [FC_W-1:0] FC_FLOOR    = 14'd2600;

   localparam logic       CSR_SAMPLE_RATE = 1'b0;
   localparam logic       CSR_CHANNELS    = 1'b1;
   localparam logic [1:0] LEVEL_OFF       = 2'd0;
   localparam logic [1:0] LEVEL_NORMAL    = 2'd1;
   localparam logic [1:0] LEVEL_HIGH      = 2'd2;

   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type coef_table_type [EXP_DEPTH];

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_result_type;

   // Divides a series term by its index; each arm for 2 to 14 uses a fixed divisor, others pass it through.
   function automatic u64_type div_by_index(u64_type v, int n);
      case (n)
         2:       div_by_index = v / 64'd2;
         3:       div_by_index = v / 64'd3;
         4:       div_by_index = v / 64'd4;
         5:       div_by_index = v / 64'd5;
         6:       div_by_index = v / 64'd6;
         7:       div_by_index = v / 64'd7;
         8:       div_by_index = v / 64'd8;
         9:       div_by_index = v / 64'd9;
         10:      div_by_index = v / 64'd10;
         11:      div_by_index = v / 64'd11;
         12:      div_by_index = v / 64'd12;
         13:      div_by_index = v / 64'd13;
         14:      div_by_index = v / 64'd14;
         default: div_by_index = v;
      endcase
   endfunction

   // Integer series for exp(-y), evaluated once at elaboration.
   function automatic coef_table_type build_coef_table();
      coef_table_type t;
      u64_type y;
      u64_type z;
      u64_type term;
      u64_type e;
      longint  sum;
      for (int k = 0; k < EXP_DEPTH; k++) begin
         y = (TWO_PI_Q30 * u64_type'(k)) / (EXP_DEPTH - 1);
         z = y >> 3;
         term = ONE_Q30;
         sum = longint'(ONE_Q30);
         for (int n = 1; n <= 14; n++) begin
            term = div_by_index((term * z) >> 30, n);
            if (n[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         e = (sum > 0) ? u64_type'(sum) : 64'd0;
         for (int n = 0; n < 3; n++) begin
            e = (e * e) >> 30;
         end
         t[k] = COEF_W'((ONE_Q30 - e + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam coef_table_type COEF_TABLE = build_coef_table();

endpackage

[rtl/slnc_divider.sv]
// Restoring divider for the cutoff ratio, one quotient bit per cycle.
module slnc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [slnc_pkg::FC_W-1:0]     numer,
   input  logic [slnc_pkg::SR_W-1:0]     denom,
   output slnc_pkg::div_result_type      result
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [$clog2(slnc_pkg::Q_W)-1:0] cnt_ff;
   logic [slnc_pkg::SR_W-1:0]   den_ff;
   logic [slnc_pkg::SR_W-1:0]   rem_ff;
   logic [slnc_pkg::Q_W-1:0]    q_ff;
   logic [slnc_pkg::SR_W:0]     rem_sh_in;
   logic                        fits_in;

   // The remainder always stays below the divisor, so one compare per bit.
   assign rem_sh_in = {rem_ff, 1'b0};
   assign fits_in   = rem_sh_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            den_ff  <= denom;
            rem_ff  <= {{(slnc_pkg::SR_W - slnc_pkg::FC_W){1'b0}}, numer};
            q_ff    <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits_in ? slnc_pkg::SR_W'(rem_sh_in - {1'b0, den_ff})
                              : slnc_pkg::SR_W'(rem_sh_in);
            q_ff   <= {q_ff[slnc_pkg::Q_W-2:0], fits_in};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == $clog2(slnc_pkg::Q_W)'(slnc_pkg::Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = q_ff;

endmodule

[rtl/scratch_lowpass_noise_colorer.sv]
// Top level of the scratch low-pass noise colorer: sequencer, shared multiplier and state.
//
// Each item on the req_ channel is one stereo frame with its scratch rate, deck gain,
// platter-held flag and realism level; each item on the rsp_ channel is the processed
// frame. An item is taken when req_valid is high and req_stall is low; req_stall is high
// for the whole time an item is in work. A result waits in the output register while
// rsp_stall is high and the block may already take and work on the next item.
// Registers are written over the csr_ channel (index 0 sample rate, index 1 channels in
// use); csr_ready is always high. The user must write them only while the block is idle;
// the block does not enforce it. Writing the sample rate clears both filter accumulators
// and the noise smoother and reseeds the noise generator. An inactive item (platter not
// held, level off or no channels) goes straight from idle to the last step, which loads
// the result register. An active item runs the whole sequence, with a filter step for the
// left channel and one for the right when two are in use; one shared multiplier is used at
// most once per step of the sequencer, and the cutoff ratio comes from a restoring divider
// that yields one quotient bit per cycle and then hands the quotient over. When the cutoff
// is at or above the sample rate the division is skipped. A new item is taken only after
// the last result is loaded and the sequencer is idle, so one item is in work at a time.
// If the result register is still full, the last step waits for it to empty.
// Reset (synchronous) restores the register defaults and clears all filter and noise state.
module scratch_lowpass_noise_colorer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_sample_left,
   input  logic signed [23:0] req_sample_right,
   input  logic signed [15:0] req_scratch_rate,
   input  logic [15:0]        req_deck_gain,
   input  logic               req_platter_held,
   input  logic [1:0]         req_realism_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_out_left,
   output logic signed [23:0] rsp_out_right,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [17:0]        csr_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_INNER  = 4'd1;
   localparam logic [3:0] ST_RED    = 4'd2;
   localparam logic [3:0] ST_FC     = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_POS    = 4'd5;
   localparam logic [3:0] ST_INTERP = 4'd6;
   localparam logic [3:0] ST_AMP    = 4'd7;
   localparam logic [3:0] ST_GS     = 4'd8;
   localparam logic [3:0] ST_TG     = 4'd9;
   localparam logic [3:0] ST_LCG    = 4'd10;
   localparam logic [3:0] ST_GRV    = 4'd11;
   localparam logic [3:0] ST_TEX    = 4'd12;
   localparam logic [3:0] ST_CH0    = 4'd13;
   localparam logic [3:0] ST_CH1    = 4'd14;
   localparam logic [3:0] ST_DONE   = 4'd15;

   localparam logic signed [15:0] REV_LIMIT = -16'sd41;
   localparam logic signed [26:0] SAT_MAX   = 27'sd8388607;
   localparam logic signed [26:0] SAT_MIN   = -27'sd8388608;

   logic [3:0]               state_ff;
   logic [17:0]              sr_ff;
   logic [1:0]               nch_ff;
   logic signed [33:0]       acc0_ff, acc1_ff;
   logic signed [25:0]       groove_ff;
   logic [31:0]              seed_ff;
   logic signed [23:0]       x0_ff, x1_ff, y0_ff, y1_ff;
   logic [16:0]              sf_ff;
   logic                     rev_ff, high_ff, two_ch_ff, last_ff;
   logic [15:0]              gain_ff, inner_ff, frac_ff;
   logic [16:0]              red_ff, r_ff;
   logic [slnc_pkg::IDX_W-1:0] idx_ff;
   logic [16:0]              coef_ff;
   logic [22:0]              amp_ff;
   logic [30:0]              gs_ff;
   logic [24:0]              tg_ff;
   logic signed [23:0]       tex_ff;
   logic                     rsp_valid_ff;
   logic signed [23:0]       rsp_l_ff, rsp_r_ff;

   logic                     accept;
   logic signed [35:0]       op_a;
   logic signed [25:0]       op_b;
   logic signed [61:0]       prod;
   logic [14:0]              strength;
   logic [13:0]              base;
   logic [16:0]              rate_ext, mag_in;
   logic [13:0]              fc_raw, fc_in;
   logic [17:0]              fs_eff;
   logic                     fc_big;
   logic [16:0]              tab_lo, tab_hi;
   logic [slnc_pkg::IDX_W-1:0] idx_nx;
   logic signed [24:0]       white;
   logic signed [26:0]       grv_diff;
   logic signed [23:0]       x_cur;
   logic signed [33:0]       acc_cur, acc_in;
   logic signed [34:0]       ch_diff;
   logic signed [26:0]       v_sum;
   logic signed [23:0]       y_in;
   logic                     div_start;
   slnc_pkg::div_result_type div_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_l_ff;
   assign rsp_out_right = rsp_r_ff;

   assign strength = high_ff ? slnc_pkg::STRENGTH_HIGH : slnc_pkg::STRENGTH_NORMAL;
   assign base     = high_ff ? slnc_pkg::BASE_HIGH : slnc_pkg::BASE_NORMAL;

   // Magnitude of the rate; the most negative code maps to exactly 8.0.
   assign rate_ext = 17'(req_scratch_rate);
   assign mag_in   = rate_ext[16] ? 17'(~rate_ext + 17'd1) : rate_ext;

   assign fs_eff = (sr_ff == '0) ? 18'd1 : sr_ff;
   assign idx_nx = idx_ff + 1'b1;
   assign tab_lo = slnc_pkg::COEF_TABLE[idx_ff];
   assign tab_hi = slnc_pkg::COEF_TABLE[idx_nx];

   assign white    = $signed({1'b0, seed_ff[31:8]}) - 25'sd8388608;
   assign grv_diff = 27'(white) - 27'(groove_ff);

   assign x_cur   = (state_ff == ST_CH1) ? x1_ff : x0_ff;
   assign acc_cur = (state_ff == ST_CH1) ? acc1_ff : acc0_ff;
   assign ch_diff = 35'($signed({x_cur, 8'd0})) - 35'(acc_cur);

   // Operand selection for the one shared multiplier.
   always_comb begin
      case (state_ff)
         ST_INNER:  begin op_a = {19'd0, sf_ff};     op_b = {10'd0, slnc_pkg::K_SPEED}; end
         ST_RED:    begin op_a = {20'd0, inner_ff};  op_b = {11'd0, strength}; end
         ST_FC:     begin
            op_a = {19'd0, 17'(18'd65536 - {1'b0, red_ff})};
            op_b = {12'd0, base};
         end
         ST_POS:    begin op_a = {19'd0, r_ff};      op_b = 26'd63; end
         ST_INTERP: begin op_a = {19'd0, 17'(tab_hi - tab_lo)}; op_b = {10'd0, frac_ff}; end
         ST_AMP:    begin op_a = {19'd0, sf_ff};     op_b = {4'd0, slnc_pkg::K_AMP_SLOPE}; end
         ST_GS:     begin op_a = {20'd0, gain_ff};   op_b = {11'd0, strength}; end
         ST_TG:     begin op_a = {5'd0, gs_ff};      op_b = {3'd0, amp_ff}; end
         ST_LCG:    begin op_a = {4'd0, seed_ff};    op_b = 26'(slnc_pkg::LCG_MUL); end
         ST_GRV:    begin op_a = 36'(grv_diff);      op_b = {13'd0, slnc_pkg::K_SMOOTH}; end
         ST_TEX:    begin op_a = 36'(groove_ff);     op_b = {1'b0, tg_ff}; end
         ST_CH0,
         ST_CH1:    begin op_a = 36'(ch_diff);       op_b = {9'd0, coef_ff}; end
         default:   begin op_a = '0;                 op_b = '0; end
      endcase
   end

   assign prod = op_a * op_b;

   assign fc_raw = prod[29:16];
   assign fc_in  = (fc_raw < slnc_pkg::FC_FLOOR) ? slnc_pkg::FC_FLOOR : fc_raw;
   assign fc_big = {4'd0, fc_in} >= fs_eff;
   assign div_start = (state_ff == ST_FC) && !fc_big;

   // Filter update and output saturation for the channel in this step.
   assign acc_in = acc_cur + 34'(prod >>> 16);
   assign v_sum  = 27'(acc_in >>> 8) + 27'(tex_ff);
   always_comb begin
      if (v_sum > SAT_MAX) begin
         y_in = 24'(SAT_MAX);
      end else if (v_sum < SAT_MIN) begin
         y_in = 24'(SAT_MIN);
      end else begin
         y_in = 24'(v_sum);
      end
   end

   slnc_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (fc_in),
      .denom  (fs_eff),
      .result (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sr_ff        <= slnc_pkg::SR_RESET;
         nch_ff       <= slnc_pkg::NCH_RESET;
         acc0_ff      <= '0;
         acc1_ff      <= '0;
         groove_ff    <= '0;
         seed_ff      <= slnc_pkg::SEED_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               slnc_pkg::CSR_SAMPLE_RATE: begin
                  sr_ff     <= csr_data;
                  acc0_ff   <= '0;
                  acc1_ff   <= '0;
                  groove_ff <= '0;
                  seed_ff   <= slnc_pkg::SEED_RESET;
               end
               slnc_pkg::CSR_CHANNELS: nch_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         // The result register fills at the last step and empties when the receiver takes it.
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x0_ff     <= req_sample_left;
                  x1_ff     <= req_sample_right;
                  y0_ff     <= req_sample_left;
                  y1_ff     <= req_sample_right;
                  sf_ff     <= mag_in;
                  rev_ff    <= req_scratch_rate <= REV_LIMIT;
                  high_ff   <= req_realism_level == slnc_pkg::LEVEL_HIGH;
                  gain_ff   <= req_deck_gain;
                  two_ch_ff <= nch_ff >= 2'd2;
                  if (req_platter_held && req_realism_level != slnc_pkg::LEVEL_OFF &&
                      nch_ff != 2'd0) begin
                     state_ff <= ST_INNER;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_INNER: begin
               inner_ff <= prod[30:15] + (rev_ff ? slnc_pkg::K_REVERSE : 16'd0);
               state_ff <= ST_RED;
            end
            ST_RED: begin
               red_ff   <= prod[30:14];
               state_ff <= ST_FC;
            end
            ST_FC: begin
               // A cutoff at or above the sample rate saturates the ratio at 1.0.
               if (fc_big) begin
                  r_ff     <= 17'd65536;
                  state_ff <= ST_POS;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_res.done) begin
                  r_ff     <= {1'b0, div_res.quotient};
                  state_ff <= ST_POS;
               end
            end
            ST_POS: begin
               idx_ff   <= prod[21:16];
               frac_ff  <= prod[15:0];
               last_ff  <= prod[21:16] == slnc_pkg::IDX_W'(slnc_pkg::EXP_DEPTH - 1);
               state_ff <= ST_INTERP;
            end
            ST_INTERP: begin
               coef_ff  <= last_ff ? slnc_pkg::COEF_TABLE[slnc_pkg::EXP_DEPTH-1]
                                   : tab_lo + prod[32:16];
               state_ff <= ST_AMP;
            end
            ST_AMP: begin
               amp_ff   <= slnc_pkg::K_AMP_BASE + prod[37:15];
               state_ff <= ST_GS;
            end
            ST_GS: begin
               gs_ff    <= prod[30:0];
               state_ff <= ST_TG;
            end
            ST_TG: begin
               tg_ff    <= prod[52:28];
               state_ff <= ST_LCG;
            end
            ST_LCG: begin
               seed_ff  <= prod[31:0] + slnc_pkg::LCG_ADD;
               state_ff <= ST_GRV;
            end
            ST_GRV: begin
               groove_ff <= groove_ff + 26'(prod >>> 16);
               state_ff  <= ST_TEX;
            end
            ST_TEX: begin
               tex_ff   <= 24'(prod >>> 33);
               state_ff <= ST_CH0;
            end
            ST_CH0: begin
               acc0_ff  <= acc_in;
               y0_ff    <= y_in;
               state_ff <= two_ch_ff ? ST_CH1 : ST_DONE;
            end
            ST_CH1: begin
               acc1_ff  <= acc_in;
               y1_ff    <= y_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_l_ff     <= y0_ff;
                  rsp_r_ff     <= y1_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/slnc_checker.sv]
// Port-level assertions for the scratch low-pass noise colorer, bound to the top level.
module slnc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [23:0] req_sample_left,
   input logic signed [23:0] req_sample_right,
   input logic signed [15:0] req_scratch_rate,
   input logic [15:0]        req_deck_gain,
   input logic               req_platter_held,
   input logic [1:0]         req_realism_level,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [23:0] rsp_out_left,
   input logic signed [23:0] rsp_out_right,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic               csr_index,
   input logic [17:0]        csr_data
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_left) && $stable(rsp_out_right))
      else $error("stalled result changed");

   // An accepted item keeps the input side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not busy after an accepted item");

   // A new result only appears at the end of an item in work.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind scratch_lowpass_noise_colorer slnc_checker u_slnc_checker (.*);
